/* hw/rtl/rmtt_pkg.sv */
package rmtt_pkg;

    localparam int MAX_TASKS_DEF   = 16;
    localparam int PERIOD_BITS_DEF = 16;
    localparam int LCM_BITS        = 64;
    localparam int UTIL_BITS       = 11;
    localparam int SLOT_BITS       = 4;
    localparam int RESULT_CAP      = 16;
    localparam logic [UTIL_BITS-1:0] UTIL_MAX = '1;

    typedef struct packed {
        logic [15:0] task_period;
        logic [6:0]  task_utilization;
    } task_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] task_index;
        logic [SLOT_BITS-1:0] priority_rank;
        logic [UTIL_BITS-1:0] total_utilization;
        logic [LCM_BITS-1:0]  hyperperiod;
        logic                 hyperperiod_overflow;
        logic                 table_full;
        logic                 last;
    } result_t;

    typedef enum logic {
        ALU_DIV = 1'b0,
        ALU_MUL = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
        logic    short_len;
    } alu_cmd_t;

endpackage

/* hw/rtl/rmtt_ram.sv */
module rmtt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/rmtt_alu.sv */
module rmtt_alu #(
    parameter int PERIOD_BITS = rmtt_pkg::PERIOD_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  rmtt_pkg::alu_cmd_t                            cmd,
    input  logic [rmtt_pkg::LCM_BITS-1:0]                 dividend,
    input  logic [PERIOD_BITS-1:0]                        operand,
    output logic                                          done,
    output logic [rmtt_pkg::LCM_BITS-1:0]                 quotient,
    output logic [PERIOD_BITS-1:0]                        remainder,
    output logic [rmtt_pkg::LCM_BITS+PERIOD_BITS-1:0]     product
);

    import rmtt_pkg::*;

    localparam int PB    = PERIOD_BITS;
    localparam int CNT_W = $clog2(LCM_BITS);

    logic                  busy_reg;
    logic                  done_reg;
    alu_op_t               op_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [LCM_BITS-1:0]   word_reg;
    logic [PB-1:0]         rem_reg;
    logic [PB-1:0]         opnd_reg;
    logic [LCM_BITS+PB-1:0] acc_reg;

    logic [PB:0]            shifted;
    logic [PB:0]            diff;
    logic                   ge;
    logic [LCM_BITS+PB-1:0] addend;
    logic [LCM_BITS+PB-1:0] acc_sum;
    logic                   load;

    assign load    = cmd.start && !busy_reg;
    assign shifted = {rem_reg, word_reg[LCM_BITS-1]};
    assign ge      = shifted >= {1'b0, opnd_reg};
    assign diff    = shifted - {1'b0, opnd_reg};
    assign addend  = opnd_reg[PB-1] ? {{PB{1'b0}}, word_reg} : '0;
    assign acc_sum = {acc_reg[LCM_BITS+PB-2:0], 1'b0} + addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg   <= cmd.op;
            word_reg <= dividend;
            opnd_reg <= operand;
            rem_reg  <= '0;
            acc_reg  <= '0;
            if (cmd.op == ALU_MUL || cmd.short_len)
            begin
                cnt_reg <= CNT_W'(PB - 1);
            end
            else
            begin
                cnt_reg <= CNT_W'(LCM_BITS - 1);
            end
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (op_reg == ALU_DIV)
            begin
                rem_reg  <= ge ? diff[PB-1:0] : shifted[PB-1:0];
                word_reg <= {word_reg[LCM_BITS-2:0], ge};
            end
            else
            begin
                acc_reg  <= acc_sum;
                opnd_reg <= {opnd_reg[PB-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = word_reg;
    assign remainder = rem_reg;
    assign product   = acc_reg;

endmodule

/* hw/rtl/rate_monotonic_task_table.sv */
// a rejected insert (table full) goes straight to its result; a zero period or a saturated
// hyperperiod skips the arithmetic, else the shared unit takes the hyperperiod mod the period,
// runs the Euclid steps, divides by the gcd and multiplies by the period; each result is then
// fetched, ranked by a scan over the stored tasks and emitted in turn; a new insert is taken
// only once the last result is in the output register; reset clears the task count, the
// utilization sum and the overflow flag and sets the hyperperiod to one, not the period table
module rate_monotonic_task_table #(
    parameter int MAX_TASKS   = rmtt_pkg::MAX_TASKS_DEF,
    parameter int PERIOD_BITS = rmtt_pkg::PERIOD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              task_valid,
    output logic              task_stall,
    input  rmtt_pkg::task_t   task_data,
    output logic              result_valid,
    input  logic              result_stall,
    output rmtt_pkg::result_t result_data
);

    import rmtt_pkg::*;

    localparam int PB = PERIOD_BITS;
    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MOD   = 10'b00_0000_0010,
        S_GCD   = 10'b00_0000_0100,
        S_GCDW  = 10'b00_0000_1000,
        S_DIV   = 10'b00_0001_0000,
        S_MUL   = 10'b00_0010_0000,
        S_FETCH = 10'b00_0100_0000,
        S_LOAD  = 10'b00_1000_0000,
        S_SCAN  = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [UTIL_BITS-1:0] util_reg, util_next;
    logic [LCM_BITS-1:0]  lcm_reg, lcm_next;
    logic                 sat_reg, sat_next;
    logic [PB-1:0]        period_reg, period_next;
    logic [PB-1:0]        gcd_a_reg, gcd_a_next;
    logic [PB-1:0]        gcd_b_reg, gcd_b_next;
    logic [PB-1:0]        pi_reg, pi_next;
    logic [AW-1:0]        idx_i_reg, idx_i_next;
    logic [AW-1:0]        idx_j_reg, idx_j_next;
    logic [AW-1:0]        rank_reg, rank_next;
    logic                 full_reg, full_next;
    logic                 res_valid_reg, res_valid_next;
    result_t              res_data_reg, res_data_next;

    logic                     accept;
    logic                     is_full;
    logic [PB-1:0]            new_period;
    logic [UTIL_BITS:0]       util_sum;
    logic                     wr_en;
    logic [AW-1:0]            rd_addr;
    logic [PB-1:0]            rd_data;
    alu_cmd_t                 alu_cmd;
    logic [LCM_BITS-1:0]      alu_a;
    logic [PB-1:0]            alu_b;
    logic                     alu_done;
    logic [LCM_BITS-1:0]      alu_quo;
    logic [PB-1:0]            alu_rem;
    logic [LCM_BITS+PB-1:0]   alu_prod;
    logic                     lt;
    logic                     j_last;
    logic [7:0]               cnt8;
    logic [7:0]               n8;
    logic                     i_last;

    assign accept     = task_valid && !task_stall;
    assign task_stall = (state_reg != S_IDLE);
    assign is_full    = (count_reg == CW'(MAX_TASKS));
    assign new_period = PB'(task_data.task_period);
    assign util_sum   = {1'b0, util_reg} + (UTIL_BITS + 1)'(task_data.task_utilization);
    assign wr_en      = accept && !is_full;

    assign lt     = (rd_data < pi_reg) || (rd_data == pi_reg && idx_j_reg < idx_i_reg);
    assign j_last = (CW'(idx_j_reg) + CW'(1)) == count_reg;
    assign cnt8   = 8'(count_reg);
    assign n8     = (cnt8 > 8'(RESULT_CAP)) ? 8'(RESULT_CAP) : cnt8;
    assign i_last = (8'(idx_i_reg) + 8'd1) == n8;

    rmtt_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_TASKS)
    ) u_period_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (new_period),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rmtt_alu #(
        .PERIOD_BITS (PB)
    ) u_alu (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (alu_cmd),
        .dividend  (alu_a),
        .operand   (alu_b),
        .done      (alu_done),
        .quotient  (alu_quo),
        .remainder (alu_rem),
        .product   (alu_prod)
    );

    always_comb
    begin
        case (state_reg)
            S_FETCH: rd_addr = idx_i_reg;
            S_LOAD:  rd_addr = '0;
            S_SCAN:  rd_addr = idx_j_reg + AW'(1);
            default: rd_addr = idx_i_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        util_next      = util_reg;
        lcm_next       = lcm_reg;
        sat_next       = sat_reg;
        period_next    = period_reg;
        gcd_a_next     = gcd_a_reg;
        gcd_b_next     = gcd_b_reg;
        pi_next        = pi_reg;
        idx_i_next     = idx_i_reg;
        idx_j_next     = idx_j_reg;
        rank_next      = rank_reg;
        full_next      = full_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_data_next  = res_data_reg;
        alu_cmd        = '{start: 1'b0, op: ALU_DIV, short_len: 1'b0};
        alu_a          = lcm_reg;
        alu_b          = period_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_i_next = '0;
                    rank_next  = '0;
                    if (is_full)
                    begin
                        full_next  = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        full_next   = 1'b0;
                        count_next  = count_reg + CW'(1);
                        util_next   = util_sum[UTIL_BITS] ? UTIL_MAX : util_sum[UTIL_BITS-1:0];
                        period_next = new_period;
                        if (!sat_reg && new_period != '0)
                        begin
                            alu_cmd.start = 1'b1;
                            alu_b         = new_period;
                            state_next    = S_MOD;
                        end
                        else
                        begin
                            state_next = S_FETCH;
                        end
                    end
                end
            end

            S_MOD:
            begin
                if (alu_done)
                begin
                    gcd_a_next = period_reg;
                    gcd_b_next = alu_rem;
                    state_next = S_GCD;
                end
            end

            S_GCD:
            begin
                alu_cmd.start = 1'b1;
                if (gcd_b_reg == '0)
                begin
                    alu_b      = gcd_a_reg;
                    state_next = S_DIV;
                end
                else
                begin
                    alu_cmd.short_len = 1'b1;
                    alu_a      = {gcd_a_reg, {(LCM_BITS - PB){1'b0}}};
                    alu_b      = gcd_b_reg;
                    state_next = S_GCDW;
                end
            end

            S_GCDW:
            begin
                if (alu_done)
                begin
                    gcd_a_next = gcd_b_reg;
                    gcd_b_next = alu_rem;
                    state_next = S_GCD;
                end
            end

            S_DIV:
            begin
                if (alu_done)
                begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = ALU_MUL;
                    alu_a         = alu_quo;
                    alu_b         = period_reg;
                    state_next    = S_MUL;
                end
            end

            S_MUL:
            begin
                if (alu_done)
                begin
                    if (alu_prod[LCM_BITS+PB-1:LCM_BITS] != '0)
                    begin
                        lcm_next = '1;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        lcm_next = alu_prod[LCM_BITS-1:0];
                    end
                    state_next = S_FETCH;
                end
            end

            S_FETCH:
            begin
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                pi_next    = rd_data;
                idx_j_next = '0;
                rank_next  = '0;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                rank_next = rank_reg + AW'(lt);
                if (j_last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_j_next = idx_j_reg + AW'(1);
                end
            end

            S_EMIT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next = 1'b1;
                    res_data_next.task_index    = SLOT_BITS'(idx_i_reg);
                    res_data_next.priority_rank = SLOT_BITS'(rank_reg);
                    res_data_next.table_full    = full_reg;
                    res_data_next.last          = full_reg || i_last;
                    if (idx_i_reg == '0)
                    begin
                        res_data_next.total_utilization    = util_reg;
                        res_data_next.hyperperiod          = lcm_reg;
                        res_data_next.hyperperiod_overflow = sat_reg;
                    end
                    else
                    begin
                        res_data_next.total_utilization    = '0;
                        res_data_next.hyperperiod          = '0;
                        res_data_next.hyperperiod_overflow = 1'b0;
                    end
                    if (full_reg || i_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_i_next = idx_i_reg + AW'(1);
                        state_next = S_FETCH;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            util_reg      <= '0;
            lcm_reg       <= LCM_BITS'(1);
            sat_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            util_reg      <= util_next;
            lcm_reg       <= lcm_next;
            sat_reg       <= sat_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg   <= period_next;
        gcd_a_reg    <= gcd_a_next;
        gcd_b_reg    <= gcd_b_next;
        pi_reg       <= pi_next;
        idx_i_reg    <= idx_i_next;
        idx_j_reg    <= idx_j_next;
        rank_reg     <= rank_next;
        full_reg     <= full_next;
        res_data_reg <= res_data_next;
    end

    assign result_valid = res_valid_reg;
    assign result_data  = res_data_reg;

endmodule
